// ===== rtl/gsca_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsca_pkg
// Shared widths, constants, codes and types of the gas sensor calibration and
// alarm block.
// ----------------------------------------------------------------------------
package gsca_pkg;

   localparam int ADC_WIDTH       = 16;
   localparam int TIME_WIDTH      = 32;
   localparam int OHMS_WIDTH      = 32;
   localparam int Q16_WIDTH       = 24;
   localparam int RATIO_Q14_WIDTH = 16;
   localparam int SUPPLY_WIDTH    = 16;
   localparam int LOAD_WIDTH      = 20;
   localparam int SECONDS_WIDTH   = 16;
   localparam int ALPHA_WIDTH     = 17;
   localparam int SUM_WIDTH       = 48;
   localparam int COUNT_WIDTH     = 16;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam int RATIO_FRAC_BITS   = 16;
   localparam int MAX_CALIB_SAMPLES = 65535;
   localparam int DIVIDER_FRAC_BITS = 14;

   localparam int AO_BITS        = ADC_WIDTH + DIVIDER_FRAC_BITS;
   localparam int RS_NUM_BITS    = LOAD_WIDTH + SUPPLY_WIDTH;
   localparam int RATIO_NUM_BITS = OHMS_WIDTH + RATIO_FRAC_BITS;
   localparam int DIV_WIDTH      = (RATIO_NUM_BITS > SUM_WIDTH) ? RATIO_NUM_BITS : SUM_WIDTH;
   localparam int STEP_WIDTH     = $clog2(DIV_WIDTH + 1);

   localparam int MUL_A_WIDTH = 24;
   localparam int MUL_B_WIDTH = 20;
   localparam int PROD_WIDTH  = MUL_A_WIDTH + MUL_B_WIDTH;
   localparam int ACC_WIDTH   = 41;

   localparam int MS_PER_SECOND = 1000;
   localparam int MIN_BASELINE  = 100;
   localparam int ALPHA_ONE     = 65536;
   localparam int EMA_ROUND     = 32768;
   localparam int EMA_SHIFT     = 16;

   localparam logic [RATIO_Q14_WIDTH-1:0] RESET_DIVIDER_RATIO = 16'd16384;
   localparam logic [SUPPLY_WIDTH-1:0]    RESET_SUPPLY        = 16'd5000;
   localparam logic [LOAD_WIDTH-1:0]      RESET_LOAD          = 20'd10000;
   localparam logic [SECONDS_WIDTH-1:0]   RESET_WARMUP        = 16'd60;
   localparam logic [SECONDS_WIDTH-1:0]   RESET_CALIBRATE     = 16'd10;
   localparam logic [ALPHA_WIDTH-1:0]     RESET_ALPHA         = 17'd6554;
   localparam logic [Q16_WIDTH-1:0]       RESET_THRESHOLD     = 24'd39322;
   localparam logic [OHMS_WIDTH-1:0]      RESET_PRESET_R0     = 32'd0;

   typedef enum logic [1:0] {
      PHASE_WARMUP = 2'd0,
      PHASE_CALIB  = 2'd1,
      PHASE_RUN    = 2'd2
   } gsca_phase_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_DIVIDER_RATIO = 3'd0,
      REG_SUPPLY        = 3'd1,
      REG_LOAD          = 3'd2,
      REG_WARMUP        = 3'd3,
      REG_CALIBRATE     = 3'd4,
      REG_ALPHA         = 3'd5,
      REG_THRESHOLD     = 3'd6,
      REG_PRESET_R0     = 3'd7
   } gsca_reg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_AO_START,
      ST_AO_WAIT,
      ST_RS_MUL,
      ST_RS_START,
      ST_RS_WAIT,
      ST_PHASE,
      ST_AVG_START,
      ST_AVG_WAIT,
      ST_RATIO_START,
      ST_RATIO_WAIT,
      ST_EMA_MUL0,
      ST_EMA_MUL1,
      ST_EMA_ADD,
      ST_OUT
   } gsca_state_type;

   typedef struct packed {
      logic [RATIO_Q14_WIDTH-1:0] divider_ratio_q14;
      logic [SUPPLY_WIDTH-1:0]    supply_millivolts;
      logic [LOAD_WIDTH-1:0]      load_ohms;
      logic [SECONDS_WIDTH-1:0]   warmup_seconds;
      logic [SECONDS_WIDTH-1:0]   calibrate_seconds;
      logic [ALPHA_WIDTH-1:0]     smoothing_alpha_q16;
      logic [Q16_WIDTH-1:0]       alarm_threshold_q16;
   } gsca_cfg_type;

   typedef struct packed {
      logic                  valid;
      logic [OHMS_WIDTH-1:0] preset;
   } gsca_restart_type;

   typedef struct packed {
      logic                  start;
      logic [DIV_WIDTH-1:0]  dividend;
      logic [OHMS_WIDTH-1:0] divisor;
      logic [STEP_WIDTH-1:0] steps;
   } gsca_div_req_type;

   typedef struct packed {
      logic                 busy;
      logic                 done;
      logic [DIV_WIDTH-1:0] quotient;
   } gsca_div_res_type;

   typedef struct packed {
      logic [OHMS_WIDTH-1:0] sensor_ohms;
      logic [Q16_WIDTH-1:0]  ratio_q16;
      logic [Q16_WIDTH-1:0]  smoothed_q16;
      logic                  alarm;
      gsca_phase_type        phase;
   } gsca_result_type;

endpackage

// ===== rtl/gsca_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsca_req_if
// Sample channel: ADC millivolts and millisecond time, valid/ready.
// ----------------------------------------------------------------------------
interface gsca_req_if;
   import gsca_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [ADC_WIDTH-1:0]  adc_millivolts;
   logic [TIME_WIDTH-1:0] now_ms;

   modport source (output valid, output adc_millivolts, output now_ms, input ready);
   modport sink (input valid, input adc_millivolts, input now_ms, output ready);
endinterface

// ===== rtl/gsca_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsca_rsp_if
// Result channel: resistance, ratio, smoothed ratio, alarm and phase.
// ----------------------------------------------------------------------------
interface gsca_rsp_if;
   import gsca_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [OHMS_WIDTH-1:0] sensor_ohms;
   logic [Q16_WIDTH-1:0]  ratio_q16;
   logic [Q16_WIDTH-1:0]  smoothed_q16;
   logic                  alarm;
   logic [1:0]            phase;

   modport source (output valid, output sensor_ohms, output ratio_q16, output smoothed_q16,
                   output alarm, output phase, input ready);
   modport sink (input valid, input sensor_ohms, input ratio_q16, input smoothed_q16,
                 input alarm, input phase, output ready);
endinterface

// ===== rtl/gsca_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsca_divider
// Shared restoring divider, one quotient bit per cycle, dividend aligned to
// the top of the word and run for a given number of steps.
// ----------------------------------------------------------------------------
module gsca_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  gsca_pkg::gsca_div_req_type div_req,
   output gsca_pkg::gsca_div_res_type div_res
);
   import gsca_pkg::*;

   logic [DIV_WIDTH-1:0]  num_ff, num_in;
   logic [DIV_WIDTH-1:0]  quo_ff, quo_in;
   logic [OHMS_WIDTH-1:0] rem_ff, rem_in;
   logic [OHMS_WIDTH-1:0] divisor_ff, divisor_in;
   logic [STEP_WIDTH-1:0] count_ff, count_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [OHMS_WIDTH:0]   trial;
   logic [OHMS_WIDTH:0]   trial_diff;
   logic                  fits;

   always_comb begin
      trial      = {rem_ff, num_ff[DIV_WIDTH-1]};
      trial_diff = trial - {1'b0, divisor_ff};
      fits       = (trial >= {1'b0, divisor_ff});

      num_in     = num_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      count_in   = count_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;

      if (div_req.start) begin
         num_in     = div_req.dividend;
         quo_in     = '0;
         rem_in     = '0;
         divisor_in = div_req.divisor;
         count_in   = div_req.steps;
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         num_in   = num_ff << 1;
         quo_in   = {quo_ff[DIV_WIDTH-2:0], fits};
         rem_in   = fits ? trial_diff[OHMS_WIDTH-1:0] : trial[OHMS_WIDTH-1:0];
         count_in = count_ff - STEP_WIDTH'(1);
         if (count_ff == STEP_WIDTH'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff     <= num_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign div_res.busy     = busy_ff;
   assign div_res.done     = done_ff;
   assign div_res.quotient = quo_ff;

   assert property (@(posedge clock) disable iff (reset) div_req.start |-> !busy_ff)
      else $error("divider started while busy");
   assert property (@(posedge clock) disable iff (reset) busy_ff |-> (rem_ff < divisor_ff))
      else $error("partial remainder not below divisor");
   assert property (@(posedge clock) disable iff (reset) done_ff |-> $past(busy_ff))
      else $error("divider done without a running division");
endmodule

// ===== rtl/gsca_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsca_csr
// Configuration registers with reset defaults; a write of the preset
// baseline raises a restart toward the sequencer.
// ----------------------------------------------------------------------------
module gsca_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [gsca_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [gsca_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data,
   output gsca_pkg::gsca_cfg_type               cfg,
   output gsca_pkg::gsca_restart_type           restart
);
   import gsca_pkg::*;

   gsca_cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (gsca_reg_type'(csr_index))
            REG_DIVIDER_RATIO: begin
               cfg_in.divider_ratio_q14 = csr_write_data[RATIO_Q14_WIDTH-1:0];
            end
            REG_SUPPLY: begin
               cfg_in.supply_millivolts = csr_write_data[SUPPLY_WIDTH-1:0];
            end
            REG_LOAD: begin
               cfg_in.load_ohms = csr_write_data[LOAD_WIDTH-1:0];
            end
            REG_WARMUP: begin
               cfg_in.warmup_seconds = csr_write_data[SECONDS_WIDTH-1:0];
            end
            REG_CALIBRATE: begin
               cfg_in.calibrate_seconds = csr_write_data[SECONDS_WIDTH-1:0];
            end
            REG_ALPHA: begin
               cfg_in.smoothing_alpha_q16 = csr_write_data[ALPHA_WIDTH-1:0];
            end
            REG_THRESHOLD: begin
               cfg_in.alarm_threshold_q16 = csr_write_data[Q16_WIDTH-1:0];
            end
            REG_PRESET_R0: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.divider_ratio_q14   <= RESET_DIVIDER_RATIO;
         cfg_ff.supply_millivolts   <= RESET_SUPPLY;
         cfg_ff.load_ohms           <= RESET_LOAD;
         cfg_ff.warmup_seconds      <= RESET_WARMUP;
         cfg_ff.calibrate_seconds   <= RESET_CALIBRATE;
         cfg_ff.smoothing_alpha_q16 <= RESET_ALPHA;
         cfg_ff.alarm_threshold_q16 <= RESET_THRESHOLD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg           = cfg_ff;
   assign restart.valid = csr_write_enable && (gsca_reg_type'(csr_index) == REG_PRESET_R0);
   assign restart.preset = csr_write_data[OHMS_WIDTH-1:0];
endmodule

// ===== rtl/gsca_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsca_core
// Sequencer and datapath: output voltage, resistance, phase tracking,
// baseline average, ratio and smoothing, all divisions on one shared divider.
// ----------------------------------------------------------------------------
module gsca_core (
   input  logic                               clock,
   input  logic                               reset,
   input  gsca_pkg::gsca_cfg_type             cfg,
   input  gsca_pkg::gsca_restart_type         restart,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [gsca_pkg::ADC_WIDTH-1:0]     req_adc_millivolts,
   input  logic [gsca_pkg::TIME_WIDTH-1:0]    req_now_ms,
   output logic                               res_valid,
   input  logic                               res_ready,
   output gsca_pkg::gsca_result_type          result
);
   import gsca_pkg::*;

   gsca_state_type         state_ff, state_in;
   gsca_phase_type         phase_ff, phase_in;
   logic [TIME_WIDTH-1:0]  phase_start_ff, phase_start_in;
   logic [OHMS_WIDTH-1:0]  baseline_ff, baseline_in;
   logic [SUM_WIDTH-1:0]   sum_ff, sum_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [Q16_WIDTH-1:0]   ema_ff, ema_in;
   logic                   ema_started_ff, ema_started_in;
   logic                   alarm_ff, alarm_in;

   logic [ADC_WIDTH-1:0]    adc_ff, adc_in;
   logic [TIME_WIDTH-1:0]   now_ff, now_in;
   logic [SUPPLY_WIDTH-1:0] ao_ff, ao_in;
   logic [PROD_WIDTH-1:0]   prod_ff;
   logic [ACC_WIDTH-1:0]    acc_ff, acc_in;
   logic [OHMS_WIDTH-1:0]   rs_ff, rs_in;
   logic [Q16_WIDTH-1:0]    ratio_ff, ratio_in;
   logic [Q16_WIDTH-1:0]    smooth_ff, smooth_in;

   gsca_div_req_type div_req;
   gsca_div_res_type div_res;

   logic [MUL_A_WIDTH-1:0]     mul_a;
   logic [MUL_B_WIDTH-1:0]     mul_b;
   logic [AO_BITS-1:0]         ao_raw;
   logic [AO_BITS-1:0]         ao_clamped;
   logic                       ao_ge_supply;
   logic [SUPPLY_WIDTH-1:0]    supply_diff;
   logic [OHMS_WIDTH-1:0]      quo_sat32;
   logic [OHMS_WIDTH-1:0]      avg_final;
   logic [Q16_WIDTH-1:0]       ratio_sat;
   logic [TIME_WIDTH-1:0]      elapsed;
   logic [TIME_WIDTH-1:0]      warm_limit;
   logic [TIME_WIDTH-1:0]      cal_limit;
   logic                       warm_due;
   logic                       cal_due;
   logic                       calib_full;
   logic [RATIO_Q14_WIDTH-1:0] ratio_divisor;
   logic [COUNT_WIDTH-1:0]     count_divisor;
   logic [ALPHA_WIDTH-1:0]     alpha_clamped;
   logic [ALPHA_WIDTH-1:0]     alpha_rest;
   logic [ACC_WIDTH-1:0]       ema_sum;
   logic [Q16_WIDTH-1:0]       ema_new;

   gsca_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_res (div_res)
   );

   // arithmetic shared by several states
   always_comb begin
      ao_raw        = div_res.quotient[AO_BITS-1:0];
      ao_clamped    = (ao_raw == '0) ? AO_BITS'(1) : ao_raw;
      ao_ge_supply  = (ao_clamped >= AO_BITS'(cfg.supply_millivolts));
      supply_diff   = cfg.supply_millivolts - ao_ff;
      quo_sat32     = (|div_res.quotient[DIV_WIDTH-1:OHMS_WIDTH]) ? '1 :
                      div_res.quotient[OHMS_WIDTH-1:0];
      avg_final     = (quo_sat32 < OHMS_WIDTH'(MIN_BASELINE)) ? OHMS_WIDTH'(MIN_BASELINE) :
                      quo_sat32;
      ratio_sat     = (|div_res.quotient[DIV_WIDTH-1:Q16_WIDTH]) ? '1 :
                      div_res.quotient[Q16_WIDTH-1:0];
      elapsed       = now_ff - phase_start_ff;
      warm_limit    = TIME_WIDTH'(cfg.warmup_seconds) * TIME_WIDTH'(MS_PER_SECOND);
      cal_limit     = TIME_WIDTH'(cfg.calibrate_seconds) * TIME_WIDTH'(MS_PER_SECOND);
      warm_due      = (elapsed >= warm_limit);
      cal_due       = (elapsed >= cal_limit);
      calib_full    = (count_ff >= COUNT_WIDTH'(MAX_CALIB_SAMPLES));
      ratio_divisor = (cfg.divider_ratio_q14 == '0) ? RATIO_Q14_WIDTH'(1) :
                      cfg.divider_ratio_q14;
      count_divisor = (count_ff == '0) ? COUNT_WIDTH'(1) : count_ff;
      alpha_clamped = (cfg.smoothing_alpha_q16 > ALPHA_WIDTH'(ALPHA_ONE)) ?
                      ALPHA_WIDTH'(ALPHA_ONE) : cfg.smoothing_alpha_q16;
      alpha_rest    = ALPHA_WIDTH'(ALPHA_ONE) - alpha_clamped;
      ema_sum       = acc_ff + prod_ff[ACC_WIDTH-1:0];
      ema_new       = ema_sum[EMA_SHIFT +: Q16_WIDTH];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && !restart.valid) begin
               state_in = ST_AO_START;
            end
         end
         ST_AO_START: begin
            state_in = ST_AO_WAIT;
         end
         ST_AO_WAIT: begin
            if (div_res.done) begin
               state_in = ao_ge_supply ? ST_PHASE : ST_RS_MUL;
            end
         end
         ST_RS_MUL: begin
            state_in = ST_RS_START;
         end
         ST_RS_START: begin
            state_in = ST_RS_WAIT;
         end
         ST_RS_WAIT: begin
            if (div_res.done) begin
               state_in = ST_PHASE;
            end
         end
         ST_PHASE: begin
            priority if (phase_ff == PHASE_CALIB && cal_due) begin
               state_in = ST_AVG_START;
            end else if (phase_ff == PHASE_RUN && baseline_ff != '0) begin
               state_in = ST_RATIO_START;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_AVG_START: begin
            state_in = ST_AVG_WAIT;
         end
         ST_AVG_WAIT: begin
            if (div_res.done) begin
               state_in = ST_RATIO_START;
            end
         end
         ST_RATIO_START: begin
            state_in = ST_RATIO_WAIT;
         end
         ST_RATIO_WAIT: begin
            if (div_res.done) begin
               state_in = ST_EMA_MUL0;
            end
         end
         ST_EMA_MUL0: begin
            state_in = ST_EMA_MUL1;
         end
         ST_EMA_MUL1: begin
            state_in = ST_EMA_ADD;
         end
         ST_EMA_ADD: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // sequencer outputs: handshakes, divider requests, multiplier operands
   always_comb begin
      req_ready        = (state_ff == ST_IDLE) && !restart.valid;
      res_valid        = (state_ff == ST_OUT);
      div_req.start    = 1'b0;
      div_req.dividend = '0;
      div_req.divisor  = '0;
      div_req.steps    = '0;
      mul_a            = '0;
      mul_b            = '0;
      unique case (state_ff)
         ST_AO_START: begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_WIDTH'({adc_ff, {DIVIDER_FRAC_BITS{1'b0}}})
                               << (DIV_WIDTH - AO_BITS);
            div_req.divisor  = OHMS_WIDTH'(ratio_divisor);
            div_req.steps    = STEP_WIDTH'(AO_BITS);
         end
         ST_RS_MUL: begin
            mul_a = MUL_A_WIDTH'(cfg.load_ohms);
            mul_b = MUL_B_WIDTH'(supply_diff);
         end
         ST_RS_START: begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_WIDTH'(prod_ff[RS_NUM_BITS-1:0]) << (DIV_WIDTH - RS_NUM_BITS);
            div_req.divisor  = OHMS_WIDTH'(ao_ff);
            div_req.steps    = STEP_WIDTH'(RS_NUM_BITS);
         end
         ST_AVG_START: begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_WIDTH'(sum_ff) << (DIV_WIDTH - SUM_WIDTH);
            div_req.divisor  = OHMS_WIDTH'(count_divisor);
            div_req.steps    = STEP_WIDTH'(SUM_WIDTH);
         end
         ST_RATIO_START: begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_WIDTH'(rs_ff) << (DIV_WIDTH - OHMS_WIDTH);
            div_req.divisor  = baseline_ff;
            div_req.steps    = STEP_WIDTH'(RATIO_NUM_BITS);
         end
         ST_EMA_MUL0: begin
            mul_a = ema_ff;
            mul_b = MUL_B_WIDTH'(alpha_rest);
         end
         ST_EMA_MUL1: begin
            mul_a = ratio_ff;
            mul_b = MUL_B_WIDTH'(alpha_clamped);
         end
         default: begin
         end
      endcase
   end

   // datapath next values
   always_comb begin
      phase_in       = phase_ff;
      phase_start_in = phase_start_ff;
      baseline_in    = baseline_ff;
      sum_in         = sum_ff;
      count_in       = count_ff;
      ema_in         = ema_ff;
      ema_started_in = ema_started_ff;
      alarm_in       = alarm_ff;
      adc_in         = adc_ff;
      now_in         = now_ff;
      ao_in          = ao_ff;
      acc_in         = acc_ff;
      rs_in          = rs_ff;
      ratio_in       = ratio_ff;
      smooth_in      = smooth_ff;

      if (restart.valid) begin
         phase_in       = (restart.preset != '0) ? PHASE_RUN : PHASE_WARMUP;
         phase_start_in = '0;
         baseline_in    = restart.preset;
         sum_in         = '0;
         count_in       = '0;
         ema_in         = '0;
         ema_started_in = 1'b0;
         alarm_in       = 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               adc_in = req_adc_millivolts;
               now_in = req_now_ms;
            end
            ST_AO_WAIT: begin
               if (div_res.done) begin
                  ao_in = ao_clamped[SUPPLY_WIDTH-1:0];
                  if (ao_ge_supply) begin
                     rs_in = '0;
                  end
               end
            end
            ST_RS_WAIT: begin
               if (div_res.done) begin
                  rs_in = quo_sat32;
               end
            end
            ST_PHASE: begin
               ratio_in  = '0;
               smooth_in = '0;
               unique case (phase_ff)
                  PHASE_WARMUP: begin
                     if (warm_due) begin
                        phase_in       = PHASE_CALIB;
                        phase_start_in = now_ff;
                        sum_in         = '0;
                        count_in       = '0;
                     end
                  end
                  PHASE_CALIB: begin
                     if (!calib_full) begin
                        sum_in   = sum_ff + SUM_WIDTH'(rs_ff);
                        count_in = count_ff + COUNT_WIDTH'(1);
                     end
                  end
                  PHASE_RUN: begin
                  end
                  default: begin
                     phase_in = PHASE_WARMUP;
                  end
               endcase
            end
            ST_AVG_WAIT: begin
               if (div_res.done) begin
                  baseline_in    = avg_final;
                  phase_in       = PHASE_RUN;
                  phase_start_in = now_ff;
                  ema_in         = Q16_WIDTH'(1 << RATIO_FRAC_BITS);
                  ema_started_in = 1'b1;
               end
            end
            ST_RATIO_WAIT: begin
               if (div_res.done) begin
                  ratio_in = ratio_sat;
                  if (!ema_started_ff) begin
                     ema_in         = ratio_sat;
                     ema_started_in = 1'b1;
                  end
               end
            end
            ST_EMA_MUL1: begin
               acc_in = prod_ff[ACC_WIDTH-1:0] + ACC_WIDTH'(EMA_ROUND);
            end
            ST_EMA_ADD: begin
               ema_in    = ema_new;
               smooth_in = ema_new;
               alarm_in  = (ema_new < cfg.alarm_threshold_q16);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         phase_ff       <= PHASE_WARMUP;
         phase_start_ff <= '0;
         baseline_ff    <= RESET_PRESET_R0;
         sum_ff         <= '0;
         count_ff       <= '0;
         ema_ff         <= '0;
         ema_started_ff <= 1'b0;
         alarm_ff       <= 1'b0;
      end else begin
         state_ff       <= state_in;
         phase_ff       <= phase_in;
         phase_start_ff <= phase_start_in;
         baseline_ff    <= baseline_in;
         sum_ff         <= sum_in;
         count_ff       <= count_in;
         ema_ff         <= ema_in;
         ema_started_ff <= ema_started_in;
         alarm_ff       <= alarm_in;
      end
   end

   always_ff @(posedge clock) begin
      adc_ff    <= adc_in;
      now_ff    <= now_in;
      ao_ff     <= ao_in;
      prod_ff   <= mul_a * mul_b;
      acc_ff    <= acc_in;
      rs_ff     <= rs_in;
      ratio_ff  <= ratio_in;
      smooth_ff <= smooth_in;
   end

   assign result.sensor_ohms  = rs_ff;
   assign result.ratio_q16    = ratio_ff;
   assign result.smoothed_q16 = smooth_ff;
   assign result.alarm        = alarm_ff;
   assign result.phase        = phase_ff;

   assert property (@(posedge clock) disable iff (reset) alarm_ff |-> (phase_ff == PHASE_RUN))
      else $error("alarm raised outside run phase");
   assert property (@(posedge clock) disable iff (reset)
                    (phase_ff == PHASE_RUN) |-> (baseline_ff != '0))
      else $error("run phase with zero baseline");
   assert property (@(posedge clock) disable iff (reset)
                    (state_ff == ST_IDLE) |-> !div_res.busy)
      else $error("divider busy while sequencer idle");
endmodule

// ===== rtl/gas_sensor_calibrate_alarm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gas_sensor_calibrate_alarm
// Gas sensor Rs/R0 calibration with smoothed ratio and low-ratio alarm.
// ----------------------------------------------------------------------------
// sequence: output voltage division, then resistance multiply and division (skipped when
//    output is at or above supply), then in run the ratio division and smoothing; the beat
//    that ends calibration adds the average division first; all divisions are bit-serial
// throughput: one beat at a time; the next is taken once the result enters the
//    output register
// reset: synchronous; registers to defaults, warmup phase, no clearing pass
module gas_sensor_calibrate_alarm (
   input  logic                                 clock,
   input  logic                                 reset,
   gsca_req_if.sink                             req_chan,
   gsca_rsp_if.source                           rsp_chan,
   input  logic                                 csr_write_enable,
   input  logic [gsca_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [gsca_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);
   import gsca_pkg::*;

   gsca_cfg_type     cfg;
   gsca_restart_type restart;
   gsca_result_type  result;
   gsca_result_type  rsp_data_ff, rsp_data_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             res_valid;
   logic             res_ready;
   logic             core_ready;

   gsca_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg),
      .restart          (restart)
   );

   gsca_core u_core (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .restart            (restart),
      .req_valid          (req_chan.valid),
      .req_ready          (core_ready),
      .req_adc_millivolts (req_chan.adc_millivolts),
      .req_now_ms         (req_chan.now_ms),
      .res_valid          (res_valid),
      .res_ready          (res_ready),
      .result             (result)
   );

   // output register
   always_comb begin
      res_ready    = !rsp_valid_ff || rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (res_valid && res_ready) begin
         rsp_data_in  = result;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign req_chan.ready        = core_ready;
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.sensor_ohms  = rsp_data_ff.sensor_ohms;
   assign rsp_chan.ratio_q16    = rsp_data_ff.ratio_q16;
   assign rsp_chan.smoothed_q16 = rsp_data_ff.smoothed_q16;
   assign rsp_chan.alarm        = rsp_data_ff.alarm;
   assign rsp_chan.phase        = rsp_data_ff.phase;
endmodule
